FILE: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is applied
`define RCCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define RCCF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rccf_pkg.sv
// shared types and constants of the rc channel conditioning block
package rccf_pkg;

  localparam int CHANNELS_DEF    = 16;
  localparam int CAL_SAMPLES_DEF = 50;

  localparam int PULSE_W    = 12;
  localparam int AVG_W      = 28;
  localparam int FRAC_W     = 16;
  localparam int ENTRY_W    = PULSE_W + AVG_W;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFIFO_DEPTH = 4;

  localparam logic [PULSE_W-1:0] MID_PULSE    = 12'd1500;
  localparam logic [PULSE_W-1:0] SAFE_LOW     = 12'd1400;
  localparam logic [PULSE_W-1:0] SAFE_HIGH    = 12'd1600;
  localparam logic [PULSE_W:0]   JITTER_LIMIT = 13'sd30;
  localparam logic [PULSE_W-1:0] LOW_INIT     = 12'd2000;
  localparam logic [PULSE_W-1:0] HIGH_INIT    = 12'd1000;
  localparam logic [15:0]        ONE_Q15      = 16'h8000;

  localparam logic [3:0]  STEER_CH_RST    = 4'd0;
  localparam logic [3:0]  THROTTLE_CH_RST = 4'd1;
  localparam logic [3:0]  DIR_SW_CH_RST   = 4'd4;
  localparam logic [3:0]  RET_SW_CH_RST   = 4'd5;
  localparam logic [15:0] WEIGHT_RST      = 16'd9830;
  localparam logic [7:0]  DEADBAND_RST    = 8'd12;

  typedef enum logic [1:0] {
    PH_WAITING     = 2'd0,
    PH_CALIBRATING = 2'd1,
    PH_READY       = 2'd2,
    PH_ERROR       = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEER    = 3'd0,
    CFG_THROTTLE = 3'd1,
    CFG_DIR_SW   = 3'd2,
    CFG_RET_SW   = 3'd3,
    CFG_WEIGHT   = 3'd4,
    CFG_DEADBAND = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_PROCESS = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S2_NONE = 2'd0,
    S2_EMA  = 2'd1,
    S2_PASS = 2'd2,
    S2_CAL  = 2'd3
  } s2_mode_t;

endpackage

FILE: rtl/rccf_ram.sv
// generic single write port ram with registered read
module rccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rc_channel_calibrate_filter_top.sv
// rc channel conditioning: per-channel deadband and smoothing, stick calibration
//
// Input beats carry either a process request (one channel and its raw pulse) or a
// calibration tick (link flag plus steering and throttle pulses). Every input beat
// gives exactly one output beat, in order: the processed value (zero for ticks)
// and the system status as it stands after that beat. Configuration is a plain
// write port, to be used only while the block is idle; the block itself does not
// enforce this. A beat passes through stage 1, stage 2 and the output queue.
// Throughput: one beat per cycle unless the input is held off. Channel centers and
// filter states live in one ram with a single write port; a process beat for the
// same channel as the beat directly ahead of it waits (the smoothing update of that
// channel must finish first), and the tick that ends calibration holds the input
// while the new centers are decided and written, steering center then throttle.
// Reset: control state clears at once; every ram entry reads as center 1500 and
// filter 1500.0 through per-entry valid bits, so there is no clearing pass.
// Stall: results wait in a 4-entry output queue; the input is held off while four
// beats are in flight, and nothing is lost or repeated.
module rc_channel_calibrate_filter_top import rccf_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic                  in_link_up,
  input  logic [7:0]            in_channel,
  input  logic [PULSE_W-1:0]    in_channel_pulse,
  input  logic [PULSE_W-1:0]    in_steer_pulse,
  input  logic [PULSE_W-1:0]    in_throttle_pulse,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PULSE_W-1:0]    out_value,
  output logic [1:0]            out_system_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(CHANNELS);
  localparam logic [7:0] CH_LIMIT = 8'(CHANNELS);
  localparam logic [CNT_W-1:0] CAL_CNT = CNT_W'(CAL_SAMPLES);
  // floor(sum / CAL_SAMPLES) as a multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT = 24;
  localparam int DIV_MUL_W = DIV_SHIFT + 1;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL =
    DIV_MUL_W'(((1 << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);
  localparam int QUO_W = SUM_W + DIV_MUL_W;
  localparam logic [AVG_W-1:0] AVG_RST = {MID_PULSE, {FRAC_W{1'b0}}};
  localparam int FPTR_W = $clog2(OFIFO_DEPTH);
  localparam int FCNT_W = FPTR_W + 1;

  // configuration registers
  logic [3:0]  steer_ch_r, thr_ch_r, dir_ch_r, ret_ch_r;
  logic [15:0] weight_r;
  logic [7:0]  deadband_r;

  // calibration state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   ssum_r, tsum_r;
  logic [PULSE_W-1:0] slow_r, shigh_r, tlow_r, thigh_r;

  // stage 1
  logic               s1_vld_r;
  op_t                s1_op_r;
  logic               s1_link_r;
  logic [7:0]         s1_ch_r;
  logic [PULSE_W-1:0] s1_pulse_r, s1_sp_r, s1_tp_r;

  // stage 2
  logic               s2_vld_r;
  s2_mode_t           s2_mode_r, s2_mode_nxt;
  logic [IDX_W-1:0]   s2_idx_r;
  logic [PULSE_W-1:0] s2_center_r;
  logic [27:0]        s2_p1_r;
  logic [43:0]        s2_p2_r;
  logic [PULSE_W-1:0] s2_value_r, s2_value_nxt;
  phase_t             s2_status_r;
  logic [ENTRY_W-1:0] s2_wdata_r;

  // ram and forwarding
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CHANNELS-1:0] vld_r;
  logic               rd_vld_r;
  logic               lw_vld_r;
  logic [IDX_W-1:0]   lw_addr_r;
  logic [ENTRY_W-1:0] lw_data_r;
  logic               pend_vld_r;
  logic [IDX_W-1:0]   pend_addr_r;
  logic [ENTRY_W-1:0] pend_data_r;

  // output queue
  logic [PULSE_W-1:0] fifo_val_r [OFIFO_DEPTH];
  phase_t             fifo_st_r  [OFIFO_DEPTH];
  logic [FPTR_W-1:0]  fifo_wp_r, fifo_rp_r;
  logic [FCNT_W-1:0]  fifo_cnt_r;

  logic               in_fire, out_fire;
  logic [FCNT_W:0]    inflight;
  logic               same_ch;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_ch_r <= STEER_CH_RST;
      thr_ch_r   <= THROTTLE_CH_RST;
      dir_ch_r   <= DIR_SW_CH_RST;
      ret_ch_r   <= RET_SW_CH_RST;
      weight_r   <= WEIGHT_RST;
      deadband_r <= DEADBAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEER:    steer_ch_r <= cfg_wdata[3:0];
        CFG_THROTTLE: thr_ch_r   <= cfg_wdata[3:0];
        CFG_DIR_SW:   dir_ch_r   <= cfg_wdata[3:0];
        CFG_RET_SW:   ret_ch_r   <= cfg_wdata[3:0];
        CFG_WEIGHT:   weight_r   <= cfg_wdata;
        CFG_DEADBAND: deadband_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1 decode
  logic [IDX_W-1:0]   s1_idx;
  logic [ENTRY_W-1:0] ent;
  logic [PULSE_W-1:0] center;
  logic [AVG_W-1:0]   avg;
  logic               ch_ok, blocked, is_sw;
  logic signed [PULSE_W:0] dev;
  logic [PULSE_W:0]   dev_mag;
  logic [PULSE_W-1:0] ema_x;
  logic [15:0]        w_eff, w_rest;

  assign s1_idx = s1_ch_r[IDX_W-1:0];

  always_comb begin
    ent = rd_vld_r ? ram_rdata : {MID_PULSE, AVG_RST};
    if (lw_vld_r && lw_addr_r == s1_idx) begin
      ent = lw_data_r;
    end
    if (pend_vld_r && pend_addr_r == s1_idx) begin
      ent = pend_data_r;
    end
  end

  assign center  = ent[ENTRY_W-1:AVG_W];
  assign avg     = ent[AVG_W-1:0];
  assign ch_ok   = s1_ch_r < CH_LIMIT;
  assign blocked = (phase_r != PH_READY) &&
                   (s1_ch_r == {4'b0, steer_ch_r} || s1_ch_r == {4'b0, thr_ch_r});
  assign is_sw   = s1_ch_r == {4'b0, dir_ch_r} || s1_ch_r == {4'b0, ret_ch_r};

  assign dev     = $signed({1'b0, s1_pulse_r}) - $signed({1'b0, center});
  assign dev_mag = dev[PULSE_W] ? PULSE_W'(1'b0) - dev : dev;
  assign ema_x   = (dev_mag <= {5'b0, deadband_r}) ? center : s1_pulse_r;
  assign w_eff   = (weight_r > ONE_Q15) ? ONE_Q15 : weight_r;
  assign w_rest  = ONE_Q15 - w_eff;

  // ---------------------------------------------------------------- calibration gather
  logic               tick, gather, fresh, s1_final;
  logic [SUM_W-1:0]   ssum_base, tsum_base, ssum_nxt, tsum_nxt;
  logic [PULSE_W-1:0] slow_base, shigh_base, tlow_base, thigh_base;
  logic [CNT_W-1:0]   cnt_base, cnt_inc;

  assign tick   = s1_vld_r && s1_op_r == OP_TICK;
  assign gather = tick && s1_link_r &&
                  (phase_r == PH_WAITING || phase_r == PH_CALIBRATING);
  assign fresh  = phase_r == PH_WAITING;

  assign ssum_base  = fresh ? '0 : ssum_r;
  assign tsum_base  = fresh ? '0 : tsum_r;
  assign slow_base  = fresh ? LOW_INIT : slow_r;
  assign tlow_base  = fresh ? LOW_INIT : tlow_r;
  assign shigh_base = fresh ? HIGH_INIT : shigh_r;
  assign thigh_base = fresh ? HIGH_INIT : thigh_r;
  assign cnt_base   = fresh ? '0 : cnt_r;

  assign ssum_nxt = ssum_base + SUM_W'(s1_sp_r);
  assign tsum_nxt = tsum_base + SUM_W'(s1_tp_r);
  assign cnt_inc  = cnt_base + CNT_W'(1);
  assign s1_final = gather && (cnt_inc >= CAL_CNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ssum_r  <= '0;
      tsum_r  <= '0;
      slow_r  <= LOW_INIT;
      tlow_r  <= LOW_INIT;
      shigh_r <= HIGH_INIT;
      thigh_r <= HIGH_INIT;
    end else if (tick && !s1_link_r) begin
      cnt_r <= '0;
    end else if (gather) begin
      cnt_r   <= cnt_inc;
      ssum_r  <= ssum_nxt;
      tsum_r  <= tsum_nxt;
      slow_r  <= (s1_sp_r < slow_base)  ? s1_sp_r : slow_base;
      shigh_r <= (s1_sp_r > shigh_base) ? s1_sp_r : shigh_base;
      tlow_r  <= (s1_tp_r < tlow_base)  ? s1_tp_r : tlow_base;
      thigh_r <= (s1_tp_r > thigh_base) ? s1_tp_r : thigh_base;
    end
  end

  // ---------------------------------------------------------------- calibration decision
  logic [QUO_W-1:0]   s_quo, t_quo;
  logic [PULSE_W-1:0] s_avg, t_avg;
  logic signed [PULSE_W:0] s_jit, t_jit;
  logic               cal_pass, steer_ok, thr_ok;
  logic [IDX_W-1:0]   steer_idx, thr_idx;

  assign s_quo    = QUO_W'(ssum_r) * QUO_W'(DIV_MUL);
  assign t_quo    = QUO_W'(tsum_r) * QUO_W'(DIV_MUL);
  assign s_avg    = s_quo[DIV_SHIFT +: PULSE_W];
  assign t_avg    = t_quo[DIV_SHIFT +: PULSE_W];
  assign s_jit    = $signed({1'b0, shigh_r}) - $signed({1'b0, slow_r});
  assign t_jit    = $signed({1'b0, thigh_r}) - $signed({1'b0, tlow_r});
  assign cal_pass = (s_jit < $signed(JITTER_LIMIT)) && (t_jit < $signed(JITTER_LIMIT)) &&
                    (s_avg > SAFE_LOW) && (s_avg < SAFE_HIGH) &&
                    (t_avg > SAFE_LOW) && (t_avg < SAFE_HIGH);
  assign steer_ok  = {4'b0, steer_ch_r} < CH_LIMIT;
  assign thr_ok    = {4'b0, thr_ch_r} < CH_LIMIT;
  assign steer_idx = IDX_W'({4'b0, steer_ch_r});
  assign thr_idx   = IDX_W'({4'b0, thr_ch_r});

  // ---------------------------------------------------------------- phase machine
  always_comb begin
    phase_nxt = phase_r;
    if (tick) begin
      if (!s1_link_r) begin
        phase_nxt = PH_WAITING;
      end else if (gather) begin
        phase_nxt = PH_CALIBRATING;
      end
    end
    if (s2_vld_r && s2_mode_r == S2_CAL) begin
      phase_nxt = cal_pass ? PH_READY : PH_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAITING;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // stage 1 result kind and value
  always_comb begin
    s2_mode_nxt  = S2_NONE;
    s2_value_nxt = '0;
    if (s1_op_r == OP_TICK) begin
      if (s1_final) begin
        s2_mode_nxt = S2_CAL;
      end
    end else if (!ch_ok || blocked) begin
      s2_value_nxt = MID_PULSE;
    end else if (is_sw) begin
      s2_mode_nxt  = S2_PASS;
      s2_value_nxt = s1_pulse_r;
    end else begin
      s2_mode_nxt = S2_EMA;
    end
  end

  // ---------------------------------------------------------------- pipeline registers
  assign inflight = (FCNT_W + 1)'(s1_vld_r) + (FCNT_W + 1)'(s2_vld_r) +
                    (FCNT_W + 1)'(fifo_cnt_r);
  // back-to-back beats on one channel: let the earlier smoothing update land first
  assign same_ch  = s1_vld_r && s1_op_r == OP_PROCESS &&
                    op_t'(in_operation) == OP_PROCESS && in_channel == s1_ch_r;
  assign in_ready = (inflight < (FCNT_W + 1)'(OFIFO_DEPTH)) && !s1_final && !same_ch;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= op_t'(in_operation);
      s1_link_r  <= in_link_up;
      s1_ch_r    <= in_channel;
      s1_pulse_r <= in_channel_pulse;
      s1_sp_r    <= in_steer_pulse;
      s1_tp_r    <= in_throttle_pulse;
    end
    if (s1_vld_r) begin
      s2_mode_r   <= s2_mode_nxt;
      s2_idx_r    <= s1_idx;
      s2_center_r <= center;
      s2_p1_r     <= 28'(w_eff) * 28'(ema_x);
      s2_p2_r     <= 44'(w_rest) * 44'(avg);
      s2_value_r  <= s2_value_nxt;
      s2_status_r <= phase_nxt;
      s2_wdata_r  <= {center, s1_pulse_r, {FRAC_W{1'b0}}};
    end
  end

  // ---------------------------------------------------------------- stage 2 and write port
  logic [44:0]        ema_acc;
  logic [AVG_W-1:0]   ema_avg;
  logic [PULSE_W-1:0] s2_value;
  phase_t             s2_status;

  assign ema_acc = {1'b0, s2_p1_r, {FRAC_W{1'b0}}} + {1'b0, s2_p2_r};
  assign ema_avg = ema_acc[15 +: AVG_W];

  always_comb begin
    s2_value  = s2_value_r;
    s2_status = s2_status_r;
    case (s2_mode_r)
      S2_EMA: s2_value = ema_avg[AVG_W-1:FRAC_W];
      S2_CAL: begin
        s2_value  = '0;
        s2_status = cal_pass ? PH_READY : PH_ERROR;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_idx_r;
    wr_data = s2_wdata_r;
    if (s2_vld_r) begin
      case (s2_mode_r)
        S2_EMA: begin
          wr_en   = 1'b1;
          wr_data = {s2_center_r, ema_avg};
        end
        S2_PASS: wr_en = 1'b1;
        S2_CAL: begin
          wr_en   = cal_pass && steer_ok;
          wr_addr = steer_idx;
          wr_data = {s_avg, s_avg, {FRAC_W{1'b0}}};
        end
        default: ;
      endcase
    end
    // throttle center from the previous cycle's calibration decision
    if (!wr_en && pend_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = pend_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      lw_vld_r   <= 1'b0;
      vld_r      <= '0;
    end else begin
      pend_vld_r <= s2_vld_r && s2_mode_r == S2_CAL && cal_pass && thr_ok;
      lw_vld_r   <= wr_en;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= thr_idx;
    pend_data_r <= {t_avg, t_avg, {FRAC_W{1'b0}}};
    lw_addr_r   <= wr_addr;
    lw_data_r   <= wr_data;
    rd_vld_r    <= vld_r[in_channel[IDX_W-1:0]];
  end

  rccf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (in_channel[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- output queue
  assign out_valid         = fifo_cnt_r != '0;
  assign out_fire          = out_valid && out_ready;
  assign out_value         = fifo_val_r[fifo_rp_r];
  assign out_system_status = fifo_st_r[fifo_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (s2_vld_r) begin
        fifo_wp_r <= fifo_wp_r + FPTR_W'(1);
      end
      if (out_fire) begin
        fifo_rp_r <= fifo_rp_r + FPTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FCNT_W'(s2_vld_r) - FCNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      fifo_val_r[fifo_wp_r] <= s2_value;
      fifo_st_r[fifo_wp_r]  <= s2_status;
    end
  end

endmodule

FILE: rtl/rccf_checker.sv
// port-level checks for the rc channel conditioning block, bound to the top level
`include "assert_macros.svh"

module rccf_props import rccf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PULSE_W-1:0] out_value,
  input logic [1:0]         out_system_status
);

  logic [2:0] inflight_r;

  // beats taken in and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  `RCCF_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")
  `RCCF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_system_status), "stalled output beat changed")
  `RCCF_ASSERT(a_inflight_cap, inflight_r <= 3'(OFIFO_DEPTH), "more beats in flight than the output queue holds")
  `RCCF_ASSERT(a_no_phantom, inflight_r == 3'd0 |-> !out_valid, "output beat with no beat taken in")

endmodule

bind rc_channel_calibrate_filter_top rccf_props u_rccf_checker (.*);
